// File: rtl/rnsp_pkg.sv
// Shared types, constants and the digit decoder of the radix number string parser.
package rnsp_pkg;

  localparam int MaxFracDigits = 5;
  localparam int FracCntW      = (MaxFracDigits < 2) ? 1 : $clog2(MaxFracDigits + 1);
  localparam int ValueW        = 64;
  localparam int FracOutW      = 3;
  localparam int CharW         = 8;
  localparam int RadixW        = 5;
  localparam int ApbAddrW      = 3;
  localparam int ApbDataW      = 32;
  localparam int InTdataW      = 8;
  localparam int OutTdataW     = 72;

  localparam logic [RadixW-1:0] RadixReset = 5'd10;
  localparam logic [RadixW-1:0] RadixMax   = 5'd16;
  localparam logic [RadixW-1:0] NotADigit  = 5'd16;

  localparam logic [CharW-1:0] CharMinus = 8'h2D;
  localparam logic [CharW-1:0] CharDot   = 8'h2E;
  localparam logic [CharW-1:0] CharZero  = 8'h30;
  localparam logic [CharW-1:0] CharNine  = 8'h39;
  localparam logic [CharW-1:0] CharUpA   = 8'h41;
  localparam logic [CharW-1:0] CharUpF   = 8'h46;

  // Register index taken from paddr bit 2 (registers sit at 4*i).
  localparam logic RegIdxRadix = 1'b0;

  typedef struct packed {
    logic [ValueW-1:0]   acc;
    logic [FracCntW-1:0] cnt;
    logic                neg;
    logic                in_frac;
    logic                at_start;
  } parse_state_t;

  typedef struct packed {
    logic [FracOutW-1:0] fraction_digits;
    logic [ValueW-1:0]   scaled_value;
  } result_t;

  function automatic logic [RadixW-1:0] digit_value(input logic [CharW-1:0] c);
    logic [RadixW-1:0] d;
    d = NotADigit;
    if (c >= CharZero && c <= CharNine) begin
      d = RadixW'(c - CharZero);
    end else if (c >= CharUpA && c <= CharUpF) begin
      d = RadixW'(c - CharUpA) + 5'd10;
    end
    return d;
  endfunction

endpackage

// File: rtl/rnsp_cfg.sv
// APB configuration register holding the radix.
module rnsp_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [rnsp_pkg::ApbAddrW-1:0]  paddr,
  input  logic [rnsp_pkg::ApbDataW-1:0]  pwdata,
  output logic [rnsp_pkg::ApbDataW-1:0]  prdata,
  output logic                           pready,
  output logic [rnsp_pkg::RadixW-1:0]    radix_o
);

  logic [rnsp_pkg::RadixW-1:0] radix_q, radix_d;
  logic                        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr[2] == rnsp_pkg::RegIdxRadix);

  always_comb begin
    radix_d = radix_q;
    if (wr_en) begin
      radix_d = pwdata[rnsp_pkg::RadixW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q <= rnsp_pkg::RadixReset;
    end else begin
      radix_q <= radix_d;
    end
  end

  // Read back the radix; addresses past the register map read zero.
  always_comb begin
    prdata = '0;
    if (paddr[2] == rnsp_pkg::RegIdxRadix) begin
      prdata = {{(rnsp_pkg::ApbDataW - rnsp_pkg::RadixW){1'b0}}, radix_q};
    end
  end

  assign radix_o = radix_q;

endmodule

// File: rtl/rnsp_step.sv
// Next-state and result logic for one character of the number parser.
module rnsp_step (
  input  rnsp_pkg::parse_state_t          state_i,
  input  logic [rnsp_pkg::CharW-1:0]      char_i,
  input  logic [rnsp_pkg::RadixW-1:0]     radix_i,
  output rnsp_pkg::parse_state_t          state_o,
  output logic                            emit_o,
  output rnsp_pkg::result_t               result_o
);

  logic [rnsp_pkg::RadixW-1:0] r;
  logic [rnsp_pkg::RadixW-1:0] d;
  logic                        is_digit;
  logic                        keep_digit;
  logic [rnsp_pkg::ValueW-1:0] mac;

  assign r          = (radix_i > rnsp_pkg::RadixMax) ? rnsp_pkg::RadixMax : radix_i;
  assign d          = rnsp_pkg::digit_value(char_i);
  assign is_digit   = (d < r);
  // Fraction digits fold into the same accumulator (Horner form), which
  // equals integer * radix^k + fraction modulo 2^64.
  assign keep_digit = !state_i.in_frac ||
                      (state_i.cnt < rnsp_pkg::FracCntW'(rnsp_pkg::MaxFracDigits));
  assign mac        = rnsp_pkg::ValueW'(state_i.acc * rnsp_pkg::ValueW'(r))
                    + rnsp_pkg::ValueW'(d);

  always_comb begin
    state_o          = state_i;
    state_o.at_start = 1'b0;
    emit_o           = 1'b0;
    if (state_i.at_start && char_i == rnsp_pkg::CharMinus) begin
      state_o.neg = 1'b1;
    end else if (char_i == rnsp_pkg::CharDot && !state_i.in_frac) begin
      state_o.in_frac = 1'b1;
    end else if (is_digit) begin
      if (keep_digit) begin
        state_o.acc = mac;
        if (state_i.in_frac) begin
          state_o.cnt = state_i.cnt + rnsp_pkg::FracCntW'(1);
        end
      end
    end else begin
      emit_o           = 1'b1;
      state_o.acc      = '0;
      state_o.cnt      = '0;
      state_o.neg      = 1'b0;
      state_o.in_frac  = 1'b0;
      state_o.at_start = 1'b1;
    end
  end

  assign result_o.scaled_value    = state_i.neg ? (rnsp_pkg::ValueW'(0) - state_i.acc)
                                                : state_i.acc;
  assign result_o.fraction_digits = rnsp_pkg::FracOutW'(state_i.cnt);

endmodule

// File: rtl/radix_number_string_parser_unit.sv
// Top level of the radix number string parser: input register, parse step, result register.
// A terminator that advances out of the input register loads its result into the result register.
// Throughput: one character per cycle, set by the single multiply-accumulate step; only a
// terminator stalls, held in the input register while an earlier result waits to be taken.
// Reset (rst_ni low, asynchronous): radix returns to 10, the parse state clears to the start
// of a number, and both the input and the result register are emptied.
module radix_number_string_parser_unit (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Character stream in
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [rnsp_pkg::InTdataW-1:0]    s_axis_tdata,   // [7:0] char_code
  // Result stream out
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [rnsp_pkg::OutTdataW-1:0]   m_axis_tdata,   // [63:0] scaled_value,
                                                           // [66:64] fraction_digits,
                                                           // [71:67] zero
  // Configuration
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [rnsp_pkg::ApbAddrW-1:0]    paddr,
  input  logic [rnsp_pkg::ApbDataW-1:0]    pwdata,
  output logic [rnsp_pkg::ApbDataW-1:0]    prdata,
  output logic                             pready
);

  logic [rnsp_pkg::RadixW-1:0] radix;

  // Input register
  logic                       in_valid_q, in_valid_d;
  logic [rnsp_pkg::CharW-1:0] in_char_q;

  // Parse state and result register
  rnsp_pkg::parse_state_t st_q, st_d;
  rnsp_pkg::result_t      res_q, step_res;
  logic                   out_valid_q, out_valid_d;
  logic                   emit;
  logic                   advance;

  rnsp_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .radix_o (radix)
  );

  rnsp_step u_step (
    .state_i  (st_q),
    .char_i   (in_char_q),
    .radix_i  (radix),
    .state_o  (st_d),
    .emit_o   (emit),
    .result_o (step_res)
  );

  // Advance the held character unless it is a terminator and the result slot
  // holds a result that is not taken now, so a waiting result is never overwritten.
  assign advance       = in_valid_q && (!emit || !out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  always_comb begin
    in_valid_d = in_valid_q;
    if (s_axis_tready) begin
      in_valid_d = s_axis_tvalid;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance && emit) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      st_q.acc      <= '0;
      st_q.cnt      <= '0;
      st_q.neg      <= 1'b0;
      st_q.in_frac  <= 1'b0;
      st_q.at_start <= 1'b1;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (advance) begin
        st_q <= st_d;
      end
    end
  end

  // Payload registers: load on an input transaction or an emitted result, hold otherwise.
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_char_q <= s_axis_tdata[rnsp_pkg::CharW-1:0];
    end
    if (advance && emit) begin
      res_q <= step_res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(rnsp_pkg::OutTdataW - rnsp_pkg::FracOutW - rnsp_pkg::ValueW){1'b0}},
                          res_q.fraction_digits, res_q.scaled_value};

  // A result only appears after a terminator was processed.
  a_out_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(advance && emit))
    else $error("result appeared without a terminator");

  // A terminator restarts the number from a clean state.
  a_clear_after_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && emit) |=> (st_q.at_start && !st_q.neg && !st_q.in_frac && st_q.acc == '0))
    else $error("parse state not cleared after terminator");

  // Kept fraction digits never exceed the limit, and none outside the fraction.
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q.cnt <= rnsp_pkg::FracCntW'(rnsp_pkg::MaxFracDigits)) &&
    (st_q.in_frac || st_q.cnt == '0))
    else $error("fraction digit count out of range");

  // A waiting result is never replaced while the sink stalls.
  a_hold_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready) |=> (out_valid_q && $stable(res_q)))
    else $error("waiting result overwritten");

endmodule
